// ===== rtl/cmb2d_pkg.sv =====
package cmb2d_pkg;

  localparam int unsigned DEF_MAX_X_VALUES = 16;
  localparam int unsigned DEF_MAX_Y_VALUES = 16;
  localparam int unsigned DEF_BIN_COUNT    = 65536;
  localparam int unsigned DEF_COUNT_BITS   = 32;

  localparam int unsigned CH_W      = 8;
  localparam int unsigned AX_W      = 9;
  localparam int unsigned BIN_W     = 17;
  localparam int unsigned CHAN_IN_W = 16;
  localparam int unsigned ADDR_IN_W = 16;
  localparam int unsigned OUT_W     = 32;
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [AX_W-1:0] AXIS_LIMIT = 9'd256;

  localparam logic OP_PARAM = 1'b0;
  localparam logic OP_READ  = 1'b1;
  localparam logic AXIS_X   = 1'b0;
  localparam logic AXIS_Y   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_X_CHANNELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_CHANNELS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 2'd2;

  typedef struct packed {
    logic push;
    logic clr;
  } list_ctrl_t;

  typedef struct packed {
    logic             ok;
    logic [BIN_W-1:0] bin;
  } bin_res_t;

endpackage

// ===== rtl/cmb2d_chan_list.sv =====
module cmb2d_chan_list import cmb2d_pkg::*; #(
  parameter int unsigned DEPTH = DEF_MAX_X_VALUES,
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  list_ctrl_t       ctrl_i,
  input  logic [CH_W-1:0]  chan_i,
  input  logic [IDX_W-1:0] rd_idx_i,
  output logic [CH_W-1:0]  rd_chan_o,
  output logic [CNT_W-1:0] count_o
);

  logic [CH_W-1:0]  mem_q [DEPTH];
  logic [CH_W-1:0]  rd_q;
  logic [CNT_W-1:0] count_q;
  logic             full;
  logic             wr;

  assign full = (count_q >= CNT_W'(DEPTH));
  assign wr   = ctrl_i.push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl_i.clr) begin
      count_q <= '0;
    end else if (wr) begin
      count_q <= count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[count_q[IDX_W-1:0]] <= chan_i;
    end
    rd_q <= mem_q[rd_idx_i];
  end

  assign rd_chan_o = rd_q;
  assign count_o   = count_q;

endmodule

// ===== rtl/cmb2d_bin_calc.sv =====
module cmb2d_bin_calc import cmb2d_pkg::*; #(
  parameter int unsigned BIN_COUNT = DEF_BIN_COUNT
) (
  input  logic            clk_i,
  input  logic [CH_W-1:0] xc_i,
  input  logic [CH_W-1:0] yc_i,
  input  logic [AX_W-1:0] xs_i,
  input  logic [AX_W-1:0] ys_i,
  output bin_res_t        res_o
);

  localparam int unsigned CMP_W =
    ($clog2(BIN_COUNT) + 1 > BIN_W) ? $clog2(BIN_COUNT) + 1 : BIN_W;

  logic [BIN_W-1:0] prod;
  bin_res_t         res_d;
  bin_res_t         res_q;

  always_comb begin
    prod      = BIN_W'(yc_i) * BIN_W'(xs_i);
    res_d.bin = prod + BIN_W'(xc_i);
    res_d.ok  = ({1'b0, xc_i} < xs_i) && ({1'b0, yc_i} < ys_i) &&
                (CMP_W'(res_d.bin) < CMP_W'(BIN_COUNT));
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

// ===== rtl/cmb2d_bin_ram.sv =====
module cmb2d_bin_ram import cmb2d_pkg::*; #(
  parameter int unsigned DEPTH = DEF_BIN_COUNT,
  parameter int unsigned WIDTH = DEF_COUNT_BITS,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/combo_2d_histogram_incrementer.sv =====
// Parameter item: taken in S_IDLE; with tlast it goes on to S_EV. Read item: S_RD_OUT
// waits for a free output register, then loads the registered RAM read. End-of-event
// item: S_EV, then S_LRD, S_CALC, S_MRD, S_INC per x/y pair (no S_INC if out of range),
// bounded by one shared multiply unit and the single histogram RAM. After reset the bins
// are zeroed one per cycle with input not ready; config regs reset to 256, 256, disabled.
module combo_2d_histogram_incrementer import cmb2d_pkg::*; #(
  parameter int unsigned MAX_X_VALUES = DEF_MAX_X_VALUES,
  parameter int unsigned MAX_Y_VALUES = DEF_MAX_Y_VALUES,
  parameter int unsigned BIN_COUNT    = DEF_BIN_COUNT,
  parameter int unsigned COUNT_BITS   = DEF_COUNT_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // value_valid, channel[15:0], bin_address[15:0]
  input  logic [S_TUSER_W-1:0] s_axis_tuser,  // opcode, axis_select
  input  logic                 s_axis_tlast,  // end_of_event
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_W-1:0]     m_axis_tdata,  // bin_count[31:0]
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [AX_W-1:0]      cfg_data_i
);

  localparam int unsigned XI_W   = (MAX_X_VALUES > 1) ? $clog2(MAX_X_VALUES) : 1;
  localparam int unsigned YI_W   = (MAX_Y_VALUES > 1) ? $clog2(MAX_Y_VALUES) : 1;
  localparam int unsigned XC_W   = $clog2(MAX_X_VALUES + 1);
  localparam int unsigned YC_W   = $clog2(MAX_Y_VALUES + 1);
  localparam int unsigned ADDR_W = $clog2(BIN_COUNT);
  localparam int unsigned CMP_W  = (ADDR_W + 1 > ADDR_IN_W + 1) ? ADDR_W + 1 : ADDR_IN_W + 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_OUT,
    S_EV,
    S_LRD,
    S_CALC,
    S_MRD,
    S_INC
  } state_e;

  state_e state_q, state_d;

  logic [AX_W-1:0] xch_q, ych_q;
  logic            en_q;
  logic [AX_W-1:0] xs, ys;

  logic [XI_W-1:0]   xi_q, xi_d;
  logic [YI_W-1:0]   yj_q, yj_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic              rd_oob_q, rd_oob_d;
  logic              m_valid_q, m_valid_d;
  logic [OUT_W-1:0]  m_data_q, m_data_d;

  logic                 in_acc;
  logic                 op;
  logic                 axis;
  logic                 vv;
  logic [CHAN_IN_W-1:0] chan;
  logic [ADDR_IN_W-1:0] addr;
  logic                 chan_ok;

  list_ctrl_t      x_ctrl, y_ctrl;
  logic            clr_lists;
  logic [CH_W-1:0] xc, yc;
  logic [XC_W-1:0] x_cnt;
  logic [YC_W-1:0] y_cnt;
  logic            last_x, last_y;
  logic            adv;
  bin_res_t        bin_res;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic                  ram_re;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [COUNT_BITS-1:0] ram_rdata;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign op      = s_axis_tuser[0];
  assign axis    = s_axis_tuser[1];
  assign vv      = s_axis_tdata[0];
  assign chan    = s_axis_tdata[CHAN_IN_W:1];
  assign addr    = s_axis_tdata[CHAN_IN_W+ADDR_IN_W:CHAN_IN_W+1];
  assign chan_ok = vv && (chan[CHAN_IN_W-1:CH_W] == '0);

  assign x_ctrl.push = in_acc && (op == OP_PARAM) && chan_ok && (axis == AXIS_X);
  assign y_ctrl.push = in_acc && (op == OP_PARAM) && chan_ok && (axis == AXIS_Y);
  assign x_ctrl.clr  = clr_lists;
  assign y_ctrl.clr  = clr_lists;

  assign xs = (xch_q > AXIS_LIMIT) ? AXIS_LIMIT : xch_q;
  assign ys = (ych_q > AXIS_LIMIT) ? AXIS_LIMIT : ych_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xch_q <= AXIS_LIMIT;
      ych_q <= AXIS_LIMIT;
      en_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_X_CHANNELS: xch_q <= cfg_data_i;
        CFG_Y_CHANNELS: ych_q <= cfg_data_i;
        CFG_ENABLE:     en_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  cmb2d_chan_list #(.DEPTH(MAX_X_VALUES)) u_x_list (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (x_ctrl),
    .chan_i    (chan[CH_W-1:0]),
    .rd_idx_i  (xi_q),
    .rd_chan_o (xc),
    .count_o   (x_cnt)
  );

  cmb2d_chan_list #(.DEPTH(MAX_Y_VALUES)) u_y_list (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (y_ctrl),
    .chan_i    (chan[CH_W-1:0]),
    .rd_idx_i  (yj_q),
    .rd_chan_o (yc),
    .count_o   (y_cnt)
  );

  cmb2d_bin_calc #(.BIN_COUNT(BIN_COUNT)) u_bin_calc (
    .clk_i (clk_i),
    .xc_i  (xc),
    .yc_i  (yc),
    .xs_i  (xs),
    .ys_i  (ys),
    .res_o (bin_res)
  );

  cmb2d_bin_ram #(.DEPTH(BIN_COUNT), .WIDTH(COUNT_BITS)) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign last_x = (XC_W'(xi_q) == x_cnt - XC_W'(1));
  assign last_y = (YC_W'(yj_q) == y_cnt - YC_W'(1));

  always_comb begin
    state_d    = state_q;
    xi_d       = xi_q;
    yj_d       = yj_q;
    clr_addr_d = clr_addr_q;
    rd_oob_d   = rd_oob_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_data_d   = m_data_q;
    clr_lists  = 1'b0;
    adv        = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = ADDR_W'(bin_res.bin);
    ram_wdata  = ram_rdata + COUNT_BITS'(1);
    ram_re     = 1'b0;
    ram_raddr  = ADDR_W'(bin_res.bin);

    unique case (state_q)
      S_CLEAR: begin
        ram_we     = 1'b1;
        ram_waddr  = clr_addr_q;
        ram_wdata  = '0;
        clr_addr_d = clr_addr_q + ADDR_W'(1);
        if (clr_addr_q == ADDR_W'(BIN_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (op == OP_READ) begin
            rd_oob_d  = !(CMP_W'(addr) < CMP_W'(BIN_COUNT));
            ram_re    = !rd_oob_d;
            ram_raddr = ADDR_W'(addr);
            state_d   = S_RD_OUT;
          end else if (s_axis_tlast) begin
            state_d = S_EV;
          end
        end
      end
      S_RD_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = rd_oob_q ? '0 : OUT_W'(ram_rdata);
          state_d   = S_IDLE;
        end
      end
      S_EV: begin
        xi_d = '0;
        yj_d = '0;
        if (!en_q || (x_cnt == '0) || (y_cnt == '0)) begin
          clr_lists = 1'b1;
          state_d   = S_IDLE;
        end else begin
          state_d = S_LRD;
        end
      end
      S_LRD: state_d = S_CALC;
      S_CALC: state_d = S_MRD;
      S_MRD: begin
        if (bin_res.ok) begin
          ram_re  = 1'b1;
          state_d = S_INC;
        end else begin
          adv = 1'b1;
        end
      end
      S_INC: begin
        ram_we = 1'b1;
        adv    = 1'b1;
      end
      default: state_d = S_IDLE;
    endcase

    if (adv) begin
      if (last_x) begin
        xi_d = '0;
        if (last_y) begin
          clr_lists = 1'b1;
          state_d   = S_IDLE;
        end else begin
          yj_d    = yj_q + YI_W'(1);
          state_d = S_LRD;
        end
      end else begin
        xi_d    = xi_q + XI_W'(1);
        state_d = S_LRD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_addr_q <= '0;
      m_valid_q  <= 1'b0;
      xi_q       <= '0;
      yj_q       <= '0;
      rd_oob_q   <= 1'b0;
      m_data_q   <= '0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      m_valid_q  <= m_valid_d;
      xi_q       <= xi_d;
      yj_q       <= yj_d;
      rd_oob_q   <= rd_oob_d;
      m_data_q   <= m_data_d;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_ram_write_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_CLEAR || state_q == S_INC))
    else $error("histogram written outside clear or increment");

  a_out_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == S_RD_OUT)
    else $error("result raised without a read");

  a_inc_after_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INC) |-> ($past(state_q) == S_MRD && $past(bin_res.ok)))
    else $error("increment without an in-range bin");

  a_list_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (x_cnt <= XC_W'(MAX_X_VALUES)) && (y_cnt <= YC_W'(MAX_Y_VALUES)))
    else $error("channel list count beyond depth");

endmodule

// ===== tb/sv/combo_2d_histogram_incrementer_test.sv =====
module combo_2d_histogram_incrementer_test import cmb2d_pkg::*;;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned LIST_DEPTH = 16;
  localparam int unsigned AXIS_MAX   = 256;
  localparam int unsigned SETTLE_CYC = 1100;
  localparam int unsigned WDOG_LIMIT = 200000;

  typedef struct {
    logic                 op;
    logic                 axis;
    logic                 vld;
    logic [CHAN_IN_W-1:0] chan;
    logic                 last;
    logic [ADDR_IN_W-1:0] addr;
    bit                   drain;
  } hist_item_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [S_TUSER_W-1:0] s_axis_tuser = '0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [AX_W-1:0]      cfg_data_i = '0;

  hist_item_t       item_q[$];
  logic [OUT_W-1:0] bin_count_q[$];
  int unsigned      pushed_cnt = 0;
  int unsigned      accepted_cnt = 0;
  int unsigned      errors = 0;
  int unsigned      idle_cyc = 0;
  bit               no_idle = 1'b0;
  logic             in_acc = 1'b0;
  int unsigned      tx_gap = 0;
  int unsigned      rx_wait = 0;
  int unsigned      cur_x = AXIS_MAX;
  int unsigned      cur_y = AXIS_MAX;

  // histogram predictor state
  logic [OUT_W-1:0] hist_mem [DEF_BIN_COUNT];
  logic [CH_W-1:0]  x_list [LIST_DEPTH];
  logic [CH_W-1:0]  y_list [LIST_DEPTH];
  int unsigned      x_cnt = 0;
  int unsigned      y_cnt = 0;
  logic [AX_W-1:0]  x_size_reg = 9'd256;
  logic [AX_W-1:0]  y_size_reg = 9'd256;
  logic             en_reg = 1'b0;

  combo_2d_histogram_incrementer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    foreach (hist_mem[i]) hist_mem[i] = '0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned eff_size(input int unsigned reg_val);
    if (reg_val > AXIS_MAX) return AXIS_MAX;
    return reg_val;
  endfunction

  function automatic logic [CHAN_IN_W-1:0] pick_chan(input int unsigned sz);
    int unsigned r;
    int unsigned s;
    r = $urandom_range(0, 99);
    s = (sz == 0) ? AXIS_MAX : sz;
    if (r < 45) return CHAN_IN_W'($urandom_range(0, (s > 4) ? 3 : s - 1));
    if (r < 80) return CHAN_IN_W'($urandom_range(0, s - 1));
    if (r < 90) return CHAN_IN_W'($urandom_range(0, AXIS_MAX - 1));
    return CHAN_IN_W'($urandom_range(AXIS_MAX, 65535));
  endfunction

  task automatic tally_event();
    int unsigned xs;
    int unsigned ys;
    int unsigned bin;
    xs = eff_size(x_size_reg);
    ys = eff_size(y_size_reg);
    if (en_reg) begin
      for (int j = 0; j < y_cnt; j++) begin
        if (y_list[j] < ys) begin
          for (int i = 0; i < x_cnt; i++) begin
            if (x_list[i] < xs) begin
              bin = x_list[i] + y_list[j] * xs;
              if (bin < DEF_BIN_COUNT) hist_mem[bin] = hist_mem[bin] + 1'b1;
            end
          end
        end
      end
    end
    x_cnt = 0;
    y_cnt = 0;
  endtask

  // predict on accepted input, check accepted output, watchdog
  always @(posedge clk_i) begin : predict_check
    logic                 op;
    logic                 axis;
    logic                 vld;
    logic [CHAN_IN_W-1:0] chan;
    logic [ADDR_IN_W-1:0] addr;
    logic [OUT_W-1:0]     want;
    bit                   busy;
    busy = 1'b0;
    in_acc <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (cfg_we_i) begin
        busy = 1'b1;
        case (cfg_idx_i)
          CFG_X_CHANNELS: x_size_reg = cfg_data_i;
          CFG_Y_CHANNELS: y_size_reg = cfg_data_i;
          CFG_ENABLE:     en_reg = cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        busy = 1'b1;
        accepted_cnt++;
        op   = s_axis_tuser[0];
        axis = s_axis_tuser[1];
        vld  = s_axis_tdata[0];
        chan = s_axis_tdata[16:1];
        addr = s_axis_tdata[32:17];
        if (op == OP_READ) begin
          bin_count_q.push_back((addr < DEF_BIN_COUNT) ? hist_mem[addr] : '0);
        end else begin
          if (vld && chan < AXIS_MAX) begin
            if (axis == AXIS_X && x_cnt < LIST_DEPTH) begin
              x_list[x_cnt] = chan[CH_W-1:0];
              x_cnt++;
            end else if (axis == AXIS_Y && y_cnt < LIST_DEPTH) begin
              y_list[y_cnt] = chan[CH_W-1:0];
              y_cnt++;
            end
          end
          if (s_axis_tlast) tally_event();
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        busy = 1'b1;
        if (bin_count_q.size() == 0) begin
          $error("unexpected bin_count transfer: actual %0d", m_axis_tdata);
          errors++;
        end else begin
          want = bin_count_q.pop_front();
          if (m_axis_tdata !== want) begin
            $error("bin_count mismatch: expected %0d actual %0d", want, m_axis_tdata);
            errors++;
          end
        end
      end
    end
    if (busy) idle_cyc = 0;
    else idle_cyc++;
    if (idle_cyc >= WDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // sender
  always @(negedge clk_i) begin : drive_items
    hist_item_t it;
    logic       nv;
    if (rst_ni && !(s_axis_tvalid && !in_acc)) begin
      nv = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (item_q.size() > 0 && !(item_q[0].drain && bin_count_q.size() != 0)) begin
        it = item_q.pop_front();
        s_axis_tuser <= {it.axis, it.op};
        s_axis_tdata <= {7'b0, it.addr, it.chan, it.vld};
        s_axis_tlast <= it.last;
        nv = 1'b1;
        tx_gap = pick_gap();
      end
      s_axis_tvalid <= nv;
    end
  end

  // receiver
  always @(negedge clk_i) begin : drive_ready
    if (rx_wait > 0) begin
      rx_wait--;
      m_axis_tready <= 1'b0;
    end else begin
      rx_wait = pick_gap();
      m_axis_tready <= (rx_wait == 0);
    end
  end

  task automatic push_item(input hist_item_t it);
    item_q.push_back(it);
    pushed_cnt++;
  endtask

  task automatic send_param(input logic axis, input logic vld, input int unsigned chan,
                            input logic last);
    hist_item_t it;
    it.op    = OP_PARAM;
    it.axis  = axis;
    it.vld   = vld;
    it.chan  = chan[CHAN_IN_W-1:0];
    it.last  = last;
    it.addr  = ADDR_IN_W'($urandom_range(0, 65535));
    it.drain = 1'b0;
    push_item(it);
  endtask

  task automatic send_read(input int unsigned addr, input bit drain);
    hist_item_t it;
    it.op    = OP_READ;
    it.axis  = 1'($urandom_range(0, 1));
    it.vld   = 1'($urandom_range(0, 1));
    it.chan  = CHAN_IN_W'($urandom_range(0, 65535));
    it.last  = 1'($urandom_range(0, 1));
    it.addr  = addr[ADDR_IN_W-1:0];
    it.drain = drain;
    push_item(it);
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    while (accepted_cnt != pushed_cnt || bin_count_q.size() != 0) @(negedge clk_i);
  endtask

  // end-of-event items give no result, so let any increment pass finish
  task automatic settle();
    wait_drain();
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[AX_W-1:0];
  endtask

  task automatic set_axes(input int unsigned xv, input int unsigned yv, input logic en);
    write_reg(CFG_X_CHANNELS, xv);
    write_reg(CFG_Y_CHANNELS, yv);
    write_reg(CFG_ENABLE, 32'(en));
    if ($urandom_range(0, 1)) write_reg(CFG_UNUSED, $urandom_range(0, 511));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_x = eff_size(xv);
    cur_y = eff_size(yv);
  endtask

  task automatic gen_traffic(input int unsigned n);
    int unsigned cnt;
    int unsigned r;
    int unsigned len;
    int unsigned xe;
    logic        axis;
    cnt = 0;
    xe = (cur_x == 0) ? 1 : cur_x;
    while (cnt < n) begin
      r = $urandom_range(0, 99);
      if (r < 22) begin
        if ($urandom_range(0, 1))
          send_read($urandom_range(0, 3) + $urandom_range(0, 3) * xe,
                    $urandom_range(0, 99) == 0);
        else
          send_read($urandom_range(0, 65535), 1'b0);
        cnt++;
      end else if (r < 27) begin
        send_param(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
        cnt++;
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 20);
        for (int k = 0; k < len; k++) begin
          axis = 1'($urandom_range(0, 1));
          send_param(axis, $urandom_range(0, 9) != 0,
                     pick_chan(axis == AXIS_X ? cur_x : cur_y),
                     (k == len - 1) && ($urandom_range(0, 19) != 0));
        end
        cnt += len;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (!s_axis_tready) @(negedge clk_i);

    set_axes(256, 256, 1'b1);
    send_read(0, 1'b0);
    send_read(65535, 1'b0);
    send_param(AXIS_X, 1'b1, 0, 1'b0);
    send_param(AXIS_X, 1'b1, 255, 1'b0);
    send_param(AXIS_Y, 1'b1, 255, 1'b0);
    send_param(AXIS_Y, 1'b1, 0, 1'b0);
    send_param(AXIS_X, 1'b0, 5, 1'b0);
    send_param(AXIS_X, 1'b1, 256, 1'b0);
    send_param(AXIS_Y, 1'b1, 65535, 1'b0);
    send_param(AXIS_Y, 1'b0, 9, 1'b1);
    send_read(0, 1'b0);
    send_read(255, 1'b0);
    send_read(65280, 1'b0);
    send_read(65535, 1'b0);
    send_param(AXIS_X, 1'b1, 3, 1'b0);
    send_param(AXIS_Y, 1'b1, 7, 1'b1);
    send_read(3 + 7 * 256, 1'b1);
    send_param(AXIS_X, 1'b0, 0, 1'b1);
    send_read(3 + 7 * 256, 1'b0);
    gen_traffic(200);
    settle();

    set_axes(0, 256, 1'b1);
    gen_traffic(150);
    settle();
    set_axes(511, 300, 1'b1);
    gen_traffic(200);
    settle();
    set_axes(1, 1, 1'b1);
    gen_traffic(150);
    settle();
    set_axes(16, 200, 1'b0);
    gen_traffic(150);
    settle();
    no_idle = 1'b1;
    set_axes(16, 200, 1'b1);
    gen_traffic(150);
    settle();
    no_idle = 1'b0;
    repeat (3) begin
      set_axes($urandom_range(1, 256), $urandom_range(1, 256), 1'b1);
      gen_traffic(200);
      settle();
    end

    if (bin_count_q.size() != 0) begin
      $error("bin_count transfers missing: %0d still expected", bin_count_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== combo_2d_histogram_incrementer.f =====
rtl/cmb2d_pkg.sv
rtl/cmb2d_chan_list.sv
rtl/cmb2d_bin_calc.sv
rtl/cmb2d_bin_ram.sv
rtl/combo_2d_histogram_incrementer.sv
tb/sv/combo_2d_histogram_incrementer_test.sv
